// ----- rtl/serial_frame_deframer_top_defines.svh -----
// ----------------------------------------------------------------------------
// Serial frame deframer assertion macros
// Shared property macros for the assertions in the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define SERIAL_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// ----- rtl/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial frame deframer package
// Frame layout constants and the control bundle shared by the deframer files.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int ByteW           = 8;
  localparam int HdrBytes        = 5;
  localparam int MaxPayloadBytes = 8;
  localparam int PayloadW        = MaxPayloadBytes * ByteW;

  // Positions of the header fields inside the frame store.
  localparam int IdxHeader = 0;
  localparam int IdxKind   = 1;
  localparam int IdxCmd    = 2;
  localparam int IdxDest   = 3;
  localparam int IdxLength = 4;

  // Control bundle from the frame sequencer to the datapath.
  typedef struct packed {
    logic hunting;   // waiting for a start byte
    logic last_pos;  // next byte is the checksum byte
    logic shift_en;  // shift the accepted byte into the cell row
    logic emit;      // checksum byte accepted, capture a result
    logic sum_ok;    // checksum byte equals the running sum
  } sfd_ctrl_t;

endpackage

// ----- rtl/sfd_cell.sv -----
// ----------------------------------------------------------------------------
// Deframer byte cell
// One stage of the frame store row; loads its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module sfd_cell import sfd_pkg::*; (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic [ByteW-1:0] d_i,
  output logic [ByteW-1:0] q_o
);

  logic [ByteW-1:0] byte_q;
  logic [ByteW-1:0] byte_d;

  assign byte_d = shift_i ? d_i : byte_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign q_o = byte_q;

endmodule

// ----- rtl/sfd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Deframer sequencer
// Tracks the position inside a frame and the running 8-bit checksum.
// ----------------------------------------------------------------------------
module sfd_ctrl import sfd_pkg::*; #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic [ByteW-1:0] start_marker_i,
  output sfd_ctrl_t        ctrl_o
);

  localparam int FrameBytes = HdrBytes + PAYLOAD_BYTES + 2;
  localparam int PosW       = $clog2(FrameBytes);
  localparam logic [PosW-1:0] LastPos = PosW'(FrameBytes - 1);
  localparam logic [PosW-1:0] FirstPos = PosW'(1);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic             hunting;
  logic             last_pos;
  logic             shift_en;

  assign hunting  = (pos_q == '0);
  assign last_pos = (pos_q == LastPos);

  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    shift_en = 1'b0;
    if (accept_i) begin
      if (hunting) begin
        if (rx_byte_i == start_marker_i) begin
          sum_d = rx_byte_i;
          pos_d = FirstPos;
        end
      end else if (last_pos) begin
        pos_d = '0;
        sum_d = '0;
      end else begin
        shift_en = 1'b1;
        sum_d    = sum_q + rx_byte_i;
        pos_d    = pos_q + FirstPos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  assign ctrl_o.hunting  = hunting;
  assign ctrl_o.last_pos = last_pos;
  assign ctrl_o.shift_en = shift_en;
  assign ctrl_o.emit     = accept_i && last_pos;
  assign ctrl_o.sum_ok   = (rx_byte_i == sum_q);

endmodule

// ----- rtl/serial_frame_deframer_top.sv -----
// ----------------------------------------------------------------------------
// Serial frame deframer
// Recovers start-byte framed messages with an additive checksum from a byte
// stream and presents the unpacked header and payload of each frame.
// ----------------------------------------------------------------------------
// The deframer takes one received byte per clock cycle on the input channel
// unless it stalls on a checksum byte. While hunting, bytes that differ from
// the configured start marker are dropped. A start byte opens a frame of
// PAYLOAD_BYTES + 7 bytes; the header and data bytes shift one cell per
// accepted byte through a row of byte cells, and a sequencer keeps the frame
// position and the 8-bit wrapping sum. When the checksum byte arrives, one
// result transaction is written into the output register in the same cycle,
// carrying frame_ok and the unpacked fields; a corrupt frame still produces a
// result, with frame_ok low. The result appears on the output in the cycle after
// the checksum byte is accepted. The input keeps accepting bytes while a
// result waits; it stalls only when a checksum byte arrives while the previous
// result has not been taken. The start marker is written through its own
// channel, which is always ready, and should only change while no frame is in
// progress.
// ----------------------------------------------------------------------------
module serial_frame_deframer_top import sfd_pkg::*; #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ByteW-1:0]    start_marker_i,
  // Received byte channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    rx_byte_i,
  // Frame result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                frame_ok_o,
  output logic [2:0]          priority_res_o,
  output logic                eeprom_ram_o,
  output logic                read_write_o,
  output logic                remote_o,
  output logic [ByteW-1:0]    msg_kind_o,
  output logic [ByteW-1:0]    command_o,
  output logic [ByteW-1:0]    destination_o,
  output logic [3:0]          data_length_o,
  output logic [PayloadW-1:0] payload_o
);

  `include "serial_frame_deframer_top_defines.svh"

  localparam int StoreDepth = HdrBytes + PAYLOAD_BYTES;

  // Start marker register.
  logic [ByteW-1:0] marker_q, marker_d;

  // Handshake and control.
  logic      in_accept;
  logic      out_valid_q, out_valid_d;
  sfd_ctrl_t ctrl;

  // Frame store row; cell 0 ends up holding the header byte.
  logic [ByteW-1:0] cell_q [StoreDepth];

  // Result register.
  logic                frame_ok_q;
  logic [2:0]          priority_res_q;
  logic                eeprom_ram_q;
  logic                read_write_q;
  logic                remote_q;
  logic [ByteW-1:0]    msg_kind_q;
  logic [ByteW-1:0]    command_q;
  logic [ByteW-1:0]    destination_q;
  logic [3:0]          data_length_q;
  logic [PayloadW-1:0] payload_q;
  logic [PayloadW-1:0] payload_w;

  // The configuration channel never stalls.
  assign cfg_ready_o = 1'b1;
  assign marker_d    = (cfg_valid_i) ? start_marker_i : marker_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= '0;
    end else begin
      marker_q <= marker_d;
    end
  end

  // Only the checksum byte needs room in the result register, so ordinary
  // bytes keep flowing while a finished result waits to be taken.
  assign in_ready_o = !(ctrl.last_pos && out_valid_q && !out_ready_i);
  assign in_accept  = in_valid_i && in_ready_o;

  sfd_ctrl #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .rx_byte_i     (rx_byte_i),
    .start_marker_i(marker_q),
    .ctrl_o        (ctrl)
  );

  // Bytes enter at the far end of the row and move one cell toward cell 0 on
  // every header and data byte, so after the last data byte cell k holds frame slot k.
  for (genvar gk = 0; gk < StoreDepth; gk++) begin : g_cell
    logic [ByteW-1:0] cell_d;
    if (gk == StoreDepth - 1) begin : g_tail
      assign cell_d = rx_byte_i;
    end else begin : g_link
      assign cell_d = cell_q[gk+1];
    end
    sfd_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(ctrl.shift_en),
      .d_i    (cell_d),
      .q_o    (cell_q[gk])
    );
  end

  // Pack the data bytes, first received byte in the low bits; unused byte
  // lanes read as zero.
  for (genvar gp = 0; gp < MaxPayloadBytes; gp++) begin : g_pay
    if (gp < PAYLOAD_BYTES) begin : g_used
      assign payload_w[gp*ByteW +: ByteW] = cell_q[HdrBytes+gp];
    end else begin : g_zero
      assign payload_w[gp*ByteW +: ByteW] = '0;
    end
  end

  // Result valid: set by a checksum byte, cleared when the transaction is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result fields are captured from the cell row as the checksum byte lands.
  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      frame_ok_q     <= ctrl.sum_ok;
      priority_res_q <= cell_q[IdxHeader][7:5];
      eeprom_ram_q   <= cell_q[IdxHeader][4];
      read_write_q   <= cell_q[IdxHeader][3];
      remote_q       <= cell_q[IdxHeader][0];
      msg_kind_q     <= cell_q[IdxKind];
      command_q      <= cell_q[IdxCmd];
      destination_q  <= cell_q[IdxDest];
      data_length_q  <= cell_q[IdxLength][7:4];
      payload_q      <= payload_w;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_ok_o     = frame_ok_q;
  assign priority_res_o = priority_res_q;
  assign eeprom_ram_o   = eeprom_ram_q;
  assign read_write_o   = read_write_q;
  assign remote_o       = remote_q;
  assign msg_kind_o     = msg_kind_q;
  assign command_o      = command_q;
  assign destination_o  = destination_q;
  assign data_length_o  = data_length_q;
  assign payload_o      = payload_q;

  // A checksum byte never overwrites a result that is still waiting.
  `SFD_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, ctrl.emit, !out_valid_q || out_ready_i)
  // Every accepted checksum byte shows up as a pending result.
  `SFD_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, ctrl.emit, out_valid_q)
  // A byte is either stored in the row or closes the frame, never both.
  `SFD_ASSERT_NOW(a_shift_excl, clk_i, rst_ni, ctrl.shift_en, !ctrl.emit && !ctrl.hunting)
  // Non-marker bytes seen while hunting leave the block hunting.
  `SFD_ASSERT_NEXT(a_hunt_hold, clk_i, rst_ni,
    in_accept && ctrl.hunting && (rx_byte_i != marker_q), ctrl.hunting)

endmodule

// ----- sim/tb_serial_frame_deframer_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial frame deframer testbench
// Streams framed and unframed bytes into the deframer with random idle bursts
// on both channels. A byte-level predictor tracks frame position, stored bytes
// and the running checksum, and every result transaction is compared field by
// field with the oldest predicted frame.
// ----------------------------------------------------------------------------
module tb_serial_frame_deframer_top;
  import sfd_pkg::*;

  localparam int ClkPeriod      = 10;
  localparam int ResetCycles    = 8;
  localparam int PayloadBytes   = MaxPayloadBytes;
  localparam int StoreDepth     = HdrBytes + PayloadBytes;
  localparam int FrameBytes     = StoreDepth + 2;
  localparam int BodyW          = StoreDepth * ByteW;
  // The result register shows the frame in the cycle after the checksum byte.
  localparam int SettleCycles   = 2;
  localparam int DrainCycles    = 4;
  localparam int WatchdogCycles = 2000;

  // One unpacked frame as it leaves the result channel.
  typedef struct packed {
    logic                frame_ok;
    logic [2:0]          priority_res;
    logic                eeprom_ram;
    logic                read_write;
    logic                remote;
    logic [ByteW-1:0]    msg_kind;
    logic [ByteW-1:0]    command;
    logic [ByteW-1:0]    destination;
    logic [3:0]          data_length;
    logic [PayloadW-1:0] payload;
  } frame_fields_t;

  // Block inputs all start at known values.
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic [ByteW-1:0]    start_marker_i = '0;
  logic                in_valid_i     = 1'b0;
  logic [ByteW-1:0]    rx_byte_i      = '0;
  logic                out_ready_i    = 1'b0;
  logic                cfg_ready_o;
  logic                in_ready_o;
  logic                out_valid_o;
  logic                frame_ok_o;
  logic [2:0]          priority_res_o;
  logic                eeprom_ram_o;
  logic                read_write_o;
  logic                remote_o;
  logic [ByteW-1:0]    msg_kind_o;
  logic [ByteW-1:0]    command_o;
  logic [ByteW-1:0]    destination_o;
  logic [3:0]          data_length_o;
  logic [PayloadW-1:0] payload_o;

  // Predictor state: frame position (zero while hunting), captured header and
  // data bytes, wrapping sum of the frame so far, and the current start marker.
  logic [3:0]       rx_pos = '0;
  logic [ByteW-1:0] frame_bytes_q [StoreDepth];
  logic [ByteW-1:0] rx_sum = '0;
  logic [ByteW-1:0] marker_q = '0;

  frame_fields_t pending_frames [$];
  int            mismatch_count = 0;
  int            taken_bytes    = 0;
  int            in_gap_pct     = 0;
  int            out_stall_pct  = 0;
  int            stall_left     = 0;

  serial_frame_deframer_top #(
    .PAYLOAD_BYTES(PayloadBytes)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .start_marker_i (start_marker_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_ok_o     (frame_ok_o),
    .priority_res_o (priority_res_o),
    .eeprom_ram_o   (eeprom_ram_o),
    .read_write_o   (read_write_o),
    .remote_o       (remote_o),
    .msg_kind_o     (msg_kind_o),
    .command_o      (command_o),
    .destination_o  (destination_o),
    .data_length_o  (data_length_o),
    .payload_o      (payload_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor: advances the frame state by one accepted byte. The checksum
  // byte closes the frame and yields the unpacked fields; every other byte
  // either is dropped while hunting or is stored and added to the sum.
  // --------------------------------------------------------------------------
  task automatic deframe_byte(input logic [ByteW-1:0] b, output bit emitted,
                              output frame_fields_t f);
    logic [ByteW-1:0] hdr;
    emitted = 1'b0;
    f       = '0;
    if (rx_pos == 0) begin
      if (b == marker_q) begin
        rx_sum = b;
        rx_pos = 4'd1;
      end
    end else if (rx_pos < FrameBytes - 1) begin
      frame_bytes_q[rx_pos - 4'd1] = b;
      rx_sum = rx_sum + b;
      rx_pos = rx_pos + 4'd1;
    end else begin
      hdr            = frame_bytes_q[IdxHeader];
      f.frame_ok     = (b == rx_sum);
      f.priority_res = hdr[7:5];
      f.eeprom_ram   = hdr[4];
      f.read_write   = hdr[3];
      f.remote       = hdr[0];
      f.msg_kind     = frame_bytes_q[IdxKind];
      f.command      = frame_bytes_q[IdxCmd];
      f.destination  = frame_bytes_q[IdxDest];
      f.data_length  = frame_bytes_q[IdxLength][7:4];
      for (int i = 0; i < PayloadBytes; i++) begin
        f.payload[i*ByteW +: ByteW] = frame_bytes_q[HdrBytes + i];
      end
      emitted = 1'b1;
      rx_pos  = '0;
      rx_sum  = '0;
    end
  endtask

  // Sends one byte, with an optional idle burst in front of it. Valid is left
  // high after the transaction so that back-to-back bytes never drop it.
  task automatic push_rx_byte(input logic [ByteW-1:0] b);
    frame_fields_t f;
    bit            emitted;
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (rx_pos != 0 || b == marker_q) taken_bytes++;
    deframe_byte(b, emitted, f);
    if (emitted) pending_frames.push_back(f);
  endtask

  // Holds the sender off until every predicted frame has been delivered.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // The marker must not change inside a frame, so any open frame is filled up
  // with random bytes and its result collected before the write.
  task automatic write_start_marker(input logic [ByteW-1:0] value);
    while (rx_pos != 0) push_rx_byte(ByteW'($urandom_range(0, 255)));
    wait_drained();
    cfg_valid_i    <= 1'b1;
    start_marker_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    marker_q     = value;
  endtask

  // Sends marker, 13 header and data bytes, then either the correct checksum
  // or a corrupted one.
  task automatic send_frame(input logic [BodyW-1:0] body, input bit good);
    logic [ByteW-1:0] sum;
    sum = marker_q;
    push_rx_byte(marker_q);
    for (int i = 0; i < StoreDepth; i++) begin
      push_rx_byte(body[i*ByteW +: ByteW]);
      sum = sum + body[i*ByteW +: ByteW];
    end
    push_rx_byte(good ? sum : sum ^ ByteW'($urandom_range(1, 255)));
  endtask

  function automatic logic [BodyW-1:0] random_body();
    logic [BodyW-1:0] body;
    for (int i = 0; i < StoreDepth; i++) body[i*ByteW +: ByteW] = ByteW'($urandom_range(0, 255));
    return body;
  endfunction

  // A byte that is dropped while hunting.
  function automatic logic [ByteW-1:0] noise_byte();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom_range(0, 255));
    return (b == marker_q) ? b + 8'd1 : b;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall bursts on out_ready_i, and the frame checker.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_out_ready
    if (stall_left != 0) begin
      stall_left--;
    end else if (out_stall_pct != 0 && $urandom_range(0, 99) < out_stall_pct) begin
      stall_left = $urandom_range(1, 14);
    end
    out_ready_i <= (stall_left == 0);
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [PayloadW-1:0] got,
                             input logic [PayloadW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin : check_frames
    frame_fields_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("result transaction with no frame expected");
      end else begin
        want = pending_frames.pop_front();
        check_field("frame_ok",     PayloadW'(frame_ok_o),     PayloadW'(want.frame_ok));
        check_field("priority_res", PayloadW'(priority_res_o), PayloadW'(want.priority_res));
        check_field("eeprom_ram",   PayloadW'(eeprom_ram_o),   PayloadW'(want.eeprom_ram));
        check_field("read_write",   PayloadW'(read_write_o),   PayloadW'(want.read_write));
        check_field("remote",       PayloadW'(remote_o),       PayloadW'(want.remote));
        check_field("msg_kind",     PayloadW'(msg_kind_o),     PayloadW'(want.msg_kind));
        check_field("command",      PayloadW'(command_o),      PayloadW'(want.command));
        check_field("destination",  PayloadW'(destination_o),  PayloadW'(want.destination));
        check_field("data_length",  PayloadW'(data_length_o),  PayloadW'(want.data_length));
        check_field("payload",      payload_o,                 want.payload);
      end
    end
  end

  // Ends the run if no transaction completes on any channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < WatchdogCycles) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Runs on the reset marker of zero. Dropped noise, then a good frame with
  // every header bit set, extreme field values and the marker value inside
  // the payload, then a corrupt frame whose only set bits are the unused ones.
  task automatic test_directed_frames();
    push_rx_byte(8'h5A);
    push_rx_byte(8'hFF);
    send_frame({8'h55, 8'hAA, 8'h00, 8'h7F, 8'h80, 8'h01, 8'hFF, 8'h00,
                8'hFF, 8'h80, 8'hFF, 8'h00, 8'hFF}, 1'b1);
    send_frame({{PayloadBytes{8'h00}}, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h06}, 1'b0);
  endtask

  // Mostly well-formed frames with random content, mixed with noise, frames
  // that carry the marker value inside, truncated frames and drain pauses.
  task automatic test_random_traffic(input logic [ByteW-1:0] marker, input int target,
                                     input int gap_pct, input int stall_pct);
    int               stop_at;
    int               choice;
    logic [BodyW-1:0] body;
    write_start_marker(marker);
    in_gap_pct    = gap_pct;
    out_stall_pct = stall_pct;
    stop_at       = taken_bytes + target;
    while (taken_bytes < stop_at) begin
      choice = $urandom_range(0, 99);
      if (choice < 60) begin
        repeat ($urandom_range(0, 3)) push_rx_byte(noise_byte());
        send_frame(random_body(), $urandom_range(0, 3) != 0);
      end else if (choice < 72) begin
        body = random_body();
        for (int i = 0; i < StoreDepth; i++) begin
          if ($urandom_range(0, 3) == 0) body[i*ByteW +: ByteW] = marker_q;
        end
        send_frame(body, $urandom_range(0, 1) != 0);
      end else if (choice < 80) begin
        // Truncated frame: the bytes that follow complete it out of step.
        push_rx_byte(marker_q);
        repeat ($urandom_range(1, StoreDepth)) push_rx_byte(ByteW'($urandom_range(0, 255)));
      end else if (choice < 97) begin
        push_rx_byte(ByteW'($urandom_range(0, 255)));
      end else begin
        wait_drained();
      end
    end
  endtask

  // The sender stops until every result is out, then carries on.
  task automatic test_pause_until_drained();
    in_gap_pct    = 10;
    out_stall_pct = 30;
    repeat (3) send_frame(random_body(), 1'b1);
    wait_drained();
    send_frame(random_body(), 1'b0);
  endtask

  // Closing stretch with no idling on either side: frames back to back at
  // full rate.
  task automatic test_back_to_back();
    write_start_marker(ByteW'($urandom_range(0, 255)));
    in_gap_pct    = 0;
    out_stall_pct = 0;
    repeat (10) send_frame(random_body(), $urandom_range(0, 4) != 0);
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_frames();
    test_random_traffic(8'h00, 220, 10, 20);
    test_random_traffic(8'hFF, 220, 30, 40);
    test_pause_until_drained();
    test_random_traffic(ByteW'($urandom_range(1, 254)), 220, 0, 0);
    test_random_traffic(8'h80, 220, 5, 50);
    test_random_traffic(ByteW'($urandom_range(0, 255)), 220, 20, 5);
    test_back_to_back();

    // Let the last results out, then watch for stray transactions.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
